// ===== hw/rtl/dmx_priority_htp_merge_unit_macros.svh =====
// ----------------------------------------------------------------------------
// DMX priority HTP merge unit: assertion macros
// Shared concurrent assertion forms for the merge unit checkers.
// ----------------------------------------------------------------------------
`ifndef DMX_PRIORITY_HTP_MERGE_UNIT_MACROS_SVH
`define DMX_PRIORITY_HTP_MERGE_UNIT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define DMXPHM_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dmxphm assertion failed");

// Property checked on every clock edge, reset included.
`define DMXPHM_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("dmxphm assertion failed");

`endif

// ===== hw/rtl/dmxphm_pkg.sv =====
// ----------------------------------------------------------------------------
// DMX priority HTP merge package
// Transaction payload types, opcodes and the stored entry format.
// ----------------------------------------------------------------------------
package dmxphm_pkg;

   localparam logic [1:0] OP_CONTRIBUTE  = 2'd0;
   localparam logic [1:0] OP_READ        = 2'd1;
   localparam logic [1:0] OP_READ_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] universe_index;
      logic [8:0] channel;
      logic [7:0] source_priority;
      logic [7:0] level;
   } req_type;

   typedef struct packed {
      logic [7:0] merged_level;
      logic [7:0] merged_priority;
      logic       took_over;
   } rsp_type;

   typedef struct packed {
      logic [7:0] best_priority;
      logic [7:0] best_level;
   } entry_type;

   typedef struct packed {
      logic      en;
      entry_type data;
   } wr_cmd_type;

endpackage

// ===== hw/rtl/dmx_priority_htp_merge_unit.sv =====
// ----------------------------------------------------------------------------
// DMX priority HTP merge unit
// Per-channel priority merge with highest-takes-precedence at equal priority.
// ----------------------------------------------------------------------------
// The unit sustains one transaction per clock: each request reads its entry
// from the merge memory at acceptance (registered read), resolves in the
// write-back stage and writes back while loading the response register. A
// write-back to the same entry as the request being read is forwarded.
// Throughput drops only when the response register is held by rsp_ready low
// or during the clearing sweep. After reset the memory is swept to zero over
// all UNIVERSES*CHANNELS entries (2048 by default), during which req_ready
// stays low.
module dmx_priority_htp_merge_unit #(
   parameter int CHANNELS  = 512,
   parameter int UNIVERSES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dmxphm_pkg::req_type req,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dmxphm_pkg::rsp_type rsp
);
   import dmxphm_pkg::*;

   localparam int DEPTH = UNIVERSES * CHANNELS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic            accept;
   logic            store_busy;
   logic            req_ok;
   logic [AW-1:0]   req_addr;
   entry_type       rd_data;
   wr_cmd_type      wr_cmd;

   logic            s1_valid_ff, s1_valid_in;
   req_type         s1_req_ff;
   logic [AW-1:0]   s1_addr_ff;
   logic            s1_ok_ff;
   logic            fwd_ff;
   entry_type       fwd_data_ff;
   logic            s1_adv;

   entry_type       cur;
   logic            take;
   logic            op_ok;
   rsp_type         rsp_in;
   rsp_type         rsp_ff;
   logic            rsp_valid_ff, rsp_valid_in;

   assign req_ok = (32'(req.universe_index) < UNIVERSES) && (32'(req.channel) < CHANNELS);
   assign req_addr = AW'(AW'(req.universe_index) * AW'(CHANNELS)) + AW'(req.channel);

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !store_busy && (!s1_valid_ff || s1_adv);
   assign accept    = req_valid && req_ready;

   // Resolve the merge for the transaction in the write-back stage.
   always_comb begin
      cur    = fwd_ff ? fwd_data_ff : rd_data;
      op_ok  = s1_ok_ff && (s1_req_ff.op == OP_CONTRIBUTE || s1_req_ff.op == OP_READ ||
                            s1_req_ff.op == OP_READ_CLEAR);
      take   = op_ok && (s1_req_ff.op == OP_CONTRIBUTE) &&
               ((s1_req_ff.source_priority > cur.best_priority) ||
                ((s1_req_ff.source_priority == cur.best_priority) &&
                 (s1_req_ff.level > cur.best_level)));
      rsp_in = '0;
      if (op_ok) begin
         if (take) begin
            rsp_in.merged_level    = s1_req_ff.level;
            rsp_in.merged_priority = s1_req_ff.source_priority;
            rsp_in.took_over       = 1'b1;
         end else begin
            rsp_in.merged_level    = cur.best_level;
            rsp_in.merged_priority = cur.best_priority;
         end
      end
      wr_cmd.en   = s1_adv && (take || (op_ok && s1_req_ff.op == OP_READ_CLEAR));
      wr_cmd.data = '0;
      if (take) begin
         wr_cmd.data.best_priority = s1_req_ff.source_priority;
         wr_cmd.data.best_level    = s1_req_ff.level;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff   <= req;
         s1_addr_ff  <= req_addr;
         s1_ok_ff    <= req_ok;
         // Forward a same-entry write-back the memory read misses.
         fwd_ff      <= wr_cmd.en && (s1_addr_ff == req_addr);
         fwd_data_ff <= wr_cmd.data;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   dmxphm_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (rd_data),
      .wr_cmd  (wr_cmd),
      .wr_addr (s1_addr_ff),
      .busy    (store_busy)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== hw/rtl/dmxphm_store.sv =====
// ----------------------------------------------------------------------------
// DMX priority HTP merge store
// Single-port-read, single-port-write entry memory with a registered
// read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module dmxphm_store #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output dmxphm_pkg::entry_type   rd_data,
   input  dmxphm_pkg::wr_cmd_type  wr_cmd,
   input  logic [AW-1:0]           wr_addr,
   output logic                    busy
);
   import dmxphm_pkg::*;

   entry_type       mem_ff [DEPTH];
   entry_type       rd_data_ff;
   logic            busy_ff, busy_in;
   logic [AW-1:0]   clr_cnt_ff, clr_cnt_in;

   always_comb begin
      busy_in    = busy_ff;
      clr_cnt_in = clr_cnt_ff;
      if (busy_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Read returns the old contents on a same-cycle write; the caller forwards.
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem_ff[clr_cnt_ff] <= '0;
      end else if (wr_cmd.en) begin
         mem_ff[wr_addr] <= wr_cmd.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

// ===== hw/rtl/dmxphm_checker.sv =====
// ----------------------------------------------------------------------------
// DMX priority HTP merge checker
// Port-level assertions for the merge unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "dmx_priority_htp_merge_unit_macros.svh"

module dmxphm_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  dmxphm_pkg::req_type req,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  dmxphm_pkg::rsp_type rsp
);
   import dmxphm_pkg::*;

   logic [7:0] merged_or;

   assign merged_or = rsp.merged_level | rsp.merged_priority;

   // A waiting request holds.
   `DMXPHM_ASSERT(a_req_hold, clock, reset, req_valid && !req_ready |=> req_valid && $stable(req))
   // A stalled response holds.
   `DMXPHM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
   // The clearing sweep keeps requests out right after reset.
   `DMXPHM_ASSERT_ALWAYS(a_clear_blocks, clock, $past(reset) |-> !req_ready)
   // A new response rises once its transaction has passed the write-back stage and response registers.
   `DMXPHM_ASSERT(a_rsp_latency, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
   // A takeover always leaves a nonzero entry.
   `DMXPHM_ASSERT(a_take_nonzero, clock, reset, rsp_valid && rsp.took_over |-> merged_or != 8'd0)

endmodule

bind dmx_priority_htp_merge_unit dmxphm_checker u_checker (.*);
